// ===== hw/rtl/drq_pkg.sv =====
package drq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH_DEF = 8;

  // Field widths
  localparam int CYL_CFG_W = 11;
  localparam int HEADS_W   = 5;
  localparam int SPT_W     = 8;
  localparam int PRECOMP_W = 16;
  localparam int CTRL_W    = 8;
  localparam int LS_W      = 22;
  localparam int CNT_W     = 8;
  localparam int CODE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int RIDX_W    = 3;
  localparam int SLOT_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = CYL_CFG_W + HEADS_W + SPT_W;
  localparam int CYL_W     = 10;
  localparam int HD_W      = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CYLINDERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRECOMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL   = 3'd4;

  // Configuration reset values
  localparam logic [CYL_CFG_W-1:0] CYLINDERS_RST = 11'd1024;
  localparam logic [HEADS_W-1:0]   HEADS_RST     = 5'd16;
  localparam logic [SPT_W-1:0]     SPT_RST       = 8'd63;
  localparam logic [PRECOMP_W-1:0] PRECOMP_RST   = 16'hffff;
  localparam logic [CTRL_W-1:0]    CONTROL_RST   = 8'h00;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REG_WR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_XFER      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_PARAM = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DRV_ERR   = 3'd5;

  // Task file register indexes
  localparam logic [RIDX_W-1:0] REG_CTRL    = 3'd0;
  localparam logic [RIDX_W-1:0] REG_PRECOMP = 3'd1;
  localparam logic [RIDX_W-1:0] REG_COUNT   = 3'd2;
  localparam logic [RIDX_W-1:0] REG_SECTOR  = 3'd3;
  localparam logic [RIDX_W-1:0] REG_CYL_LO  = 3'd4;
  localparam logic [RIDX_W-1:0] REG_CYL_HI  = 3'd5;
  localparam logic [RIDX_W-1:0] REG_DRV_HD  = 3'd6;
  localparam logic [RIDX_W-1:0] REG_CMD     = 3'd7;

  // Task file constants
  localparam logic [7:0] DRV_HD_BASE = 8'hA0;
  localparam logic [7:0] CMD_READ    = 8'h20;
  localparam logic [7:0] CMD_WRITE   = 8'h30;

  // Stored request
  typedef struct packed {
    logic              op;
    logic [7:0]        sect;
    logic [CYL_W-1:0]  cyl;
    logic [HD_W-1:0]   hd;
    logic [CNT_W-1:0]  count;
  } drq_entry_t;

  // Sequencer states
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_MUL1   = 11'b000_0000_0010,
    ST_MUL2   = 11'b000_0000_0100,
    ST_CHECK  = 11'b000_0000_1000,
    ST_DIV1   = 11'b000_0001_0000,
    ST_DIV2   = 11'b000_0010_0000,
    ST_STORE  = 11'b000_0100_0000,
    ST_RD     = 11'b000_1000_0000,
    ST_LATCH  = 11'b001_0000_0000,
    ST_EMIT   = 11'b010_0000_0000,
    ST_SINGLE = 11'b100_0000_0000
  } drq_state_t;

endpackage

// ===== hw/rtl/drq_ram.sv =====
module drq_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/disk_request_queue_chs_issuer_core.sv =====
// Disk request queue with CHS task-file issuer. Submit items (in_tuser = 0) are checked
// against the drive geometry and the queue fill, converted from logical sector to
// cylinder/head/1-based sector and stored in a ring of QUEUE_DEPTH slots; if the queue was
// empty the eight task-file register writes follow at once, register 7 (command) last.
// Interrupt items (in_tuser = 1) report a drive error, a sector transfer, or a finished
// request followed by the register writes of the next pending one. A stored submit goes through
// two steps of one shared multiplier and a compare for the range check, then 44 steps of one
// bit-serial restoring divider that is shared by the sector-per-track and the head division,
// and one store step. A rejected submit ends after the compare with a single result. Issuing
// reads the head slot, latches the entry and then emits the register writes in order. Every
// result waits while the output register is still held by the receiver. in_tready is low
// while an item is being worked on; a result waits in the output register and the next item
// may be accepted meanwhile. Configuration may be written only while the block is idle.
module disk_request_queue_chs_issuer_core #(
  parameter int QUEUE_DEPTH = drq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [drq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drq_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] write_op, [22:1] logical_sector, [30:23] sector_count, [31] error_flag,
  // [39:32] error_code
  input  logic [39:0]                    in_tdata,
  // [0] mode
  input  logic                           in_tuser,
  // result items
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] reg_index, [10:3] reg_value, [13:11] slot, [15:14] zero
  output logic [15:0]                    out_tdata,
  // [2:0] kind
  output logic [drq_pkg::KIND_W-1:0]     out_tuser,
  output logic                           out_tlast
);

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);
  localparam int BIT_W  = $clog2(drq_pkg::LS_W);
  localparam int ENT_W  = $bits(drq_pkg::drq_entry_t);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [PEND_W-1:0] PEND_FULL = PEND_W'(QUEUE_DEPTH);
  localparam logic [BIT_W-1:0]  DIV_LAST  = BIT_W'(drq_pkg::LS_W - 1);

  // Configuration registers
  logic [drq_pkg::CYL_CFG_W-1:0] cylinders_r;
  logic [drq_pkg::HEADS_W-1:0]   heads_r;
  logic [drq_pkg::SPT_W-1:0]     spt_r;
  logic [drq_pkg::PRECOMP_W-1:0] precomp_r;
  logic [drq_pkg::CTRL_W-1:0]    control_r;

  // Sequencer and queue state
  drq_pkg::drq_state_t state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [drq_pkg::CNT_W-1:0] remsec_r, remsec_nxt;

  // Latched submit
  logic                      op_r, op_nxt;
  logic [drq_pkg::LS_W-1:0]  ls_r, ls_nxt;
  logic [drq_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // Shared arithmetic unit
  logic [drq_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [7:0]                 rem_r, rem_nxt;
  logic [drq_pkg::LS_W-1:0]   quo_r, quo_nxt;
  logic [7:0]                 div_r, div_nxt;
  logic [BIT_W-1:0]           bit_r, bit_nxt;
  logic [7:0]                 sect_r, sect_nxt;
  logic [drq_pkg::CYL_W-1:0]  cyl_r, cyl_nxt;
  logic [drq_pkg::HD_W-1:0]   hd_r, hd_nxt;

  // Single result staging
  logic [drq_pkg::KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [7:0]                 res_val_r, res_val_nxt;
  logic [2:0]                 res_slot_r, res_slot_nxt;
  logic                       res_last_r, res_last_nxt;
  logic                       issue_r, issue_nxt;
  logic [drq_pkg::RIDX_W-1:0] emit_r, emit_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic [drq_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [drq_pkg::RIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [7:0]                 out_val_r, out_val_nxt;
  logic [2:0]                 out_slot_r, out_slot_nxt;
  logic                       out_last_r, out_last_nxt;

  // Combinational helpers
  logic                       in_acc, out_free;
  logic [15:0]                mul_a;
  logic [7:0]                 mul_b;
  logic [drq_pkg::PROD_W-1:0] mul_p;
  logic [8:0]                 div_try;
  logic                       div_ge;
  logic [7:0]                 div_rem;
  logic [drq_pkg::LS_W-1:0]   div_quo;
  logic [drq_pkg::LS_W:0]     span;
  logic [IDX_W-1:0]           head_inc, tail_inc;
  logic [IDX_W+2:0]           head_ext;
  logic [2:0]                 head_slot;
  logic [drq_pkg::CNT_W-1:0]  remsec_dec;
  drq_pkg::drq_entry_t        wr_entry, rd_entry;
  logic                       ram_we, ram_re;
  logic [ENT_W-1:0]           ram_rdata;

  assign in_tready = (state_r == drq_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // One multiplier: cylinders * heads first, then that product * sectors per track
  assign mul_a = (state_r == drq_pkg::ST_MUL1) ? {5'b0_0000, cylinders_r} : prod_r[15:0];
  assign mul_b = (state_r == drq_pkg::ST_MUL1) ? {3'b000, heads_r} : spt_r;
  assign mul_p = mul_a * mul_b;

  // One restoring divider step
  assign div_try = {rem_r, quo_r[drq_pkg::LS_W-1]};
  assign div_ge  = (div_try >= {1'b0, div_r});
  assign div_rem = div_ge ? 8'(div_try - {1'b0, div_r}) : div_try[7:0];
  assign div_quo = {quo_r[drq_pkg::LS_W-2:0], div_ge};

  assign span       = {1'b0, ls_r} + {{(drq_pkg::LS_W - drq_pkg::CNT_W + 1){1'b0}}, cnt_r};
  assign head_inc   = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
  assign head_ext   = {3'b000, head_r};
  assign head_slot  = head_ext[2:0];
  assign remsec_dec = remsec_r - 1'b1;

  assign wr_entry = '{op: op_r, sect: sect_r, cyl: cyl_r, hd: hd_r, count: cnt_r};
  assign rd_entry = drq_pkg::drq_entry_t'(ram_rdata);
  assign ram_we   = (state_r == drq_pkg::ST_STORE);
  assign ram_re   = (state_r == drq_pkg::ST_RD);

  drq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_inc),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (head_inc),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    pend_nxt      = pend_r;
    remsec_nxt    = remsec_r;
    op_nxt        = op_r;
    ls_nxt        = ls_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_nxt       = div_r;
    bit_nxt       = bit_r;
    sect_nxt      = sect_r;
    cyl_nxt       = cyl_r;
    hd_nxt        = hd_r;
    res_kind_nxt  = res_kind_r;
    res_val_nxt   = res_val_r;
    res_slot_nxt  = res_slot_r;
    res_last_nxt  = res_last_r;
    issue_nxt     = issue_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      drq_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) begin
            // latch the submit and start the range check
            op_nxt    = in_tdata[0];
            ls_nxt    = in_tdata[22:1];
            cnt_nxt   = in_tdata[30:23];
            state_nxt = drq_pkg::ST_MUL1;
          end else if (pend_r != '0) begin
            res_slot_nxt = head_slot;
            res_val_nxt  = 8'h00;
            res_last_nxt = 1'b1;
            issue_nxt    = 1'b0;
            state_nxt    = drq_pkg::ST_SINGLE;
            if (in_tdata[31]) begin
              res_kind_nxt = drq_pkg::KIND_DRV_ERR;
              res_val_nxt  = in_tdata[39:32];
            end else begin
              remsec_nxt = remsec_dec;
              if (remsec_dec != '0) begin
                res_kind_nxt = drq_pkg::KIND_XFER;
              end else begin
                // request finished: retire it, issue the next if any
                res_kind_nxt = drq_pkg::KIND_DONE;
                pend_nxt     = pend_r - 1'b1;
                if (pend_r != PEND_W'(1)) begin
                  res_last_nxt = 1'b0;
                  issue_nxt    = 1'b1;
                end
              end
            end
          end
        end
      end
      drq_pkg::ST_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = drq_pkg::ST_MUL2;
      end
      drq_pkg::ST_MUL2: begin
        prod_nxt  = mul_p;
        state_nxt = drq_pkg::ST_CHECK;
      end
      drq_pkg::ST_CHECK: begin
        res_val_nxt  = 8'h00;
        res_slot_nxt = 3'd0;
        res_last_nxt = 1'b1;
        issue_nxt    = 1'b0;
        if (cnt_r == '0 || {1'b0, span} >= {1'b0, prod_r}) begin
          res_kind_nxt = drq_pkg::KIND_BAD_PARAM;
          state_nxt    = drq_pkg::ST_SINGLE;
        end else if (pend_r == PEND_FULL) begin
          res_kind_nxt = drq_pkg::KIND_FULL;
          state_nxt    = drq_pkg::ST_SINGLE;
        end else begin
          // start sector / sectors_per_track
          rem_nxt   = 8'h00;
          quo_nxt   = ls_r;
          div_nxt   = spt_r;
          bit_nxt   = '0;
          state_nxt = drq_pkg::ST_DIV1;
        end
      end
      drq_pkg::ST_DIV1: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == DIV_LAST) begin
          // sector is 1-based; go on with track / heads
          sect_nxt  = div_rem + 8'd1;
          rem_nxt   = 8'h00;
          div_nxt   = {{(8 - drq_pkg::HEADS_W){1'b0}}, heads_r};
          bit_nxt   = '0;
          state_nxt = drq_pkg::ST_DIV2;
        end
      end
      drq_pkg::ST_DIV2: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == DIV_LAST) begin
          cyl_nxt   = div_quo[drq_pkg::CYL_W-1:0];
          hd_nxt    = div_rem[drq_pkg::HD_W-1:0];
          state_nxt = drq_pkg::ST_STORE;
        end
      end
      drq_pkg::ST_STORE: begin
        tail_nxt  = tail_inc;
        pend_nxt  = pend_r + 1'b1;
        state_nxt = (pend_r == '0) ? drq_pkg::ST_RD : drq_pkg::ST_IDLE;
      end
      drq_pkg::ST_RD: begin
        head_nxt  = head_inc;
        state_nxt = drq_pkg::ST_LATCH;
      end
      drq_pkg::ST_LATCH: begin
        remsec_nxt = rd_entry.count;
        emit_nxt   = drq_pkg::REG_CTRL;
        state_nxt  = drq_pkg::ST_EMIT;
      end
      drq_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = drq_pkg::KIND_REG_WR;
          out_idx_nxt   = emit_r;
          out_slot_nxt  = head_slot;
          out_last_nxt  = (emit_r == drq_pkg::REG_CMD);
          case (emit_r)
            drq_pkg::REG_CTRL:    out_val_nxt = control_r;
            drq_pkg::REG_PRECOMP: out_val_nxt = precomp_r[9:2];
            drq_pkg::REG_COUNT:   out_val_nxt = rd_entry.count;
            drq_pkg::REG_SECTOR:  out_val_nxt = rd_entry.sect;
            drq_pkg::REG_CYL_LO:  out_val_nxt = rd_entry.cyl[7:0];
            drq_pkg::REG_CYL_HI:  out_val_nxt = {6'b00_0000, rd_entry.cyl[9:8]};
            drq_pkg::REG_DRV_HD:  out_val_nxt = drq_pkg::DRV_HD_BASE | {4'h0, rd_entry.hd};
            drq_pkg::REG_CMD:
              out_val_nxt = rd_entry.op ? drq_pkg::CMD_WRITE : drq_pkg::CMD_READ;
            default:              out_val_nxt = 8'h00;
          endcase
          emit_nxt = emit_r + 1'b1;
          if (emit_r == drq_pkg::REG_CMD) begin
            state_nxt = drq_pkg::ST_IDLE;
          end
        end
      end
      drq_pkg::ST_SINGLE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_idx_nxt   = drq_pkg::REG_CTRL;
          out_val_nxt   = res_val_r;
          out_slot_nxt  = res_slot_r;
          out_last_nxt  = res_last_r;
          state_nxt     = issue_r ? drq_pkg::ST_RD : drq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = drq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drq_pkg::ST_IDLE;
      head_r      <= IDX_LAST;
      tail_r      <= IDX_LAST;
      pend_r      <= '0;
      remsec_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      pend_r      <= pend_nxt;
      remsec_r    <= remsec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cylinders_r <= drq_pkg::CYLINDERS_RST;
      heads_r     <= drq_pkg::HEADS_RST;
      spt_r       <= drq_pkg::SPT_RST;
      precomp_r   <= drq_pkg::PRECOMP_RST;
      control_r   <= drq_pkg::CONTROL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        drq_pkg::CFG_CYLINDERS: cylinders_r <= cfg_wdata[drq_pkg::CYL_CFG_W-1:0];
        drq_pkg::CFG_HEADS:     heads_r     <= cfg_wdata[drq_pkg::HEADS_W-1:0];
        drq_pkg::CFG_SPT:       spt_r       <= cfg_wdata[drq_pkg::SPT_W-1:0];
        drq_pkg::CFG_PRECOMP:   precomp_r   <= cfg_wdata[drq_pkg::PRECOMP_W-1:0];
        drq_pkg::CFG_CONTROL:   control_r   <= cfg_wdata[drq_pkg::CTRL_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ls_r       <= ls_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    div_r      <= div_nxt;
    bit_r      <= bit_nxt;
    sect_r     <= sect_nxt;
    cyl_r      <= cyl_nxt;
    hd_r       <= hd_nxt;
    res_kind_r <= res_kind_nxt;
    res_val_r  <= res_val_nxt;
    res_slot_r <= res_slot_nxt;
    res_last_r <= res_last_nxt;
    issue_r    <= issue_nxt;
    emit_r     <= emit_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r, out_val_r, out_idx_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Queue never holds more than its depth
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_FULL)
    else $error("pending count beyond queue depth");

  // Empty queue means head has caught up with tail
  a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == '0) |-> (head_r == tail_r))
    else $error("head and tail differ with no request pending");

  // Issue only happens with a request pending
  a_issue_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == drq_pkg::ST_EMIT || state_r == drq_pkg::ST_RD) |-> (pend_r != '0))
    else $error("task file issued with empty queue");

  // A register-write burst ends on the command register
  a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == drq_pkg::KIND_REG_WR && out_last_r)
      |-> (out_idx_r == drq_pkg::REG_CMD))
    else $error("register burst ended before command");

endmodule
